[sv/rtpi_pkg.sv]
// Shared types and constant tables for the terminal palette index block.
// Holds the ANSI colour table, the cube levels and the gray ramp constants.
// No dependencies.
package rtpi_pkg;

   localparam int ChanWidth  = 8;
   localparam int IndexWidth = 8;
   localparam int DistWidth  = 18;   // three 8-bit squares summed
   localparam int DigitWidth = 3;

   localparam int AnsiCount  = 16;
   localparam int CubeCount  = 216;
   localparam int GrayCount  = 24;
   localparam int XtermBase  = 16;
   localparam int CubeSide   = 6;
   localparam int GrayBase   = 8;
   localparam int GrayStep   = 10;

   localparam logic [IndexWidth-1:0] AnsiLast  = IndexWidth'(AnsiCount - 1);
   localparam logic [IndexWidth-1:0] XtermLast = IndexWidth'(CubeCount + GrayCount - 1);
   localparam logic [IndexWidth-1:0] GrayFirst = IndexWidth'(CubeCount);
   localparam logic [DigitWidth-1:0] DigitLast = DigitWidth'(CubeSide - 1);

   // 16 standard ANSI colours, 24-bit RGB
   localparam logic [23:0] AnsiRgb [AnsiCount] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
      24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
      24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
   };

   // channel levels of the 6x6x6 cube
   localparam logic [ChanWidth-1:0] CubeLevel [CubeSide] = '{
      8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff
   };

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   // one palette entry issued to the distance unit
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [IndexWidth-1:0] index;
      rgb_type               colour;
   } probe_type;

   // distance returned by the distance unit
   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [IndexWidth-1:0] index;
      logic [DistWidth-1:0]  distance;
   } dist_type;

endpackage

[sv/rtpi_dist.sv]
// Shared squared-distance unit: two register stages, absolute channel gaps
// then the sum of their squares. Depends on rtpi_pkg.
module rtpi_dist
   import rtpi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  rgb_type   pixel,
   input  probe_type probe,
   output dist_type  result
);

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff;
   logic [IndexWidth-1:0] s1_index_ff;
   logic [ChanWidth-1:0]  gap_r_ff, gap_g_ff, gap_b_ff;
   logic [ChanWidth-1:0]  gap_r_in, gap_g_in, gap_b_in;

   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [IndexWidth-1:0] s2_index_ff;
   logic [DistWidth-1:0]  dist_ff, dist_in;
   logic [15:0]           sq_r, sq_g, sq_b;

   // stage 1: absolute gaps per channel
   always_comb begin
      s1_valid_in = probe.valid;
      gap_r_in = (pixel.red > probe.colour.red) ? pixel.red - probe.colour.red
                                                : probe.colour.red - pixel.red;
      gap_g_in = (pixel.green > probe.colour.green) ? pixel.green - probe.colour.green
                                                    : probe.colour.green - pixel.green;
      gap_b_in = (pixel.blue > probe.colour.blue) ? pixel.blue - probe.colour.blue
                                                  : probe.colour.blue - pixel.blue;
   end

   // stage 2: sum of squares
   always_comb begin
      sq_r    = 16'(gap_r_ff) * 16'(gap_r_ff);
      sq_g    = 16'(gap_g_ff) * 16'(gap_g_ff);
      sq_b    = 16'(gap_b_ff) * 16'(gap_b_ff);
      dist_in = DistWidth'(sq_r) + DistWidth'(sq_g) + DistWidth'(sq_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= probe.last;
      s1_index_ff <= probe.index;
      gap_r_ff    <= gap_r_in;
      gap_g_ff    <= gap_g_in;
      gap_b_ff    <= gap_b_in;
      s2_last_ff  <= s1_last_ff;
      s2_index_ff <= s1_index_ff;
      dist_ff     <= dist_in;
   end

   assign result = '{valid: s2_valid_ff, last: s2_last_ff,
                     index: s2_index_ff, distance: dist_ff};

endmodule

[sv/rtpi_seq.sv]
// Scan sequencer: takes a request, walks the palette one entry a cycle,
// keeps the best distance and holds the response. Depends on rtpi_pkg.
module rtpi_seq
   import rtpi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rgb_type               req_rgb,
   input  logic                  mode,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [IndexWidth-1:0] rsp_palette_index,
   output rgb_type               pixel,
   output probe_type             probe,
   input  dist_type              result
);

   typedef enum logic [3:0] {
      StIdle  = 4'b0001,
      StScan  = 4'b0010,
      StDrain = 4'b0100,
      StHold  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   rgb_type               pixel_ff, pixel_in;
   logic                  mode_ff, mode_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic [DigitWidth-1:0] cr_ff, cg_ff, cb_ff, cr_in, cg_in, cb_in;
   logic [ChanWidth-1:0]  gray_ff, gray_in;
   logic [DistWidth-1:0]  best_ff, best_in;
   logic [IndexWidth-1:0] best_idx_ff, best_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;
   logic                  accept, is_last, out_free;
   rgb_type               colour;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == StIdle);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = mode_ff ? (idx_ff == XtermLast) : (idx_ff == AnsiLast);

   // colour of the entry being issued
   always_comb begin
      colour = '{red: CubeLevel[cr_ff], green: CubeLevel[cg_ff], blue: CubeLevel[cb_ff]};
      if (!mode_ff) begin
         colour = AnsiRgb[idx_ff[3:0]];
      end else if (idx_ff >= GrayFirst) begin
         colour = '{red: gray_ff, green: gray_ff, blue: gray_ff};
      end
   end

   assign pixel = pixel_ff;
   assign probe = '{valid: (state_ff == StScan), last: is_last,
                    index: idx_ff, colour: colour};

   // sequencer and entry counters
   always_comb begin
      state_in = state_ff;
      pixel_in = pixel_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      cr_in    = cr_ff;
      cg_in    = cg_ff;
      cb_in    = cb_ff;
      gray_in  = gray_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               pixel_in = req_rgb;
               mode_in  = mode;
               idx_in   = '0;
               cr_in    = '0;
               cg_in    = '0;
               cb_in    = '0;
               gray_in  = ChanWidth'(GrayBase);
               state_in = StScan;
            end
         end
         StScan: begin
            idx_in = idx_ff + 1'b1;
            // step the cube digits, blue fastest
            if (cb_ff == DigitLast) begin
               cb_in = '0;
               if (cg_ff == DigitLast) begin
                  cg_in = '0;
                  cr_in = cr_ff + 1'b1;
               end else begin
                  cg_in = cg_ff + 1'b1;
               end
            end else begin
               cb_in = cb_ff + 1'b1;
            end
            if (idx_ff >= GrayFirst) begin
               gray_in = gray_ff + ChanWidth'(GrayStep);
            end
            if (is_last) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (result.valid && result.last) begin
               state_in = StHold;
            end
         end
         StHold: begin
            if (out_free) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // running minimum, later entry wins a tie
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (result.valid && ((result.index == '0) || (result.distance <= best_ff))) begin
         best_in     = result.distance;
         best_idx_in = result.index;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      if ((state_ff == StHold) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = mode_ff ? best_idx_ff + IndexWidth'(XtermBase) : best_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff     <= pixel_in;
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      cr_ff        <= cr_in;
      cg_ff        <= cg_in;
      cb_ff        <= cb_in;
      gray_ff      <= gray_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;

endmodule

[sv/rgb_to_terminal_palette_index.sv]
// Top level of the nearest terminal palette colour block.
// Instantiates rtpi_seq and rtpi_dist; depends on rtpi_pkg.
//
// Finds the palette entry nearest to a 24-bit RGB colour by squared distance,
// a later entry winning a tie. csr_write_data selects the palette: 0 gives the
// 16 ANSI colours (index 0..15), 1 the 6x6x6 cube plus 24 grays (16..255).
// Entries are fed one a cycle through a single two-stage distance unit, and the
// response becomes valid once the last entry's distance has left the unit and
// the output register is free; req_ready is low until then. A finished
// response sits in an output register, and the next request is taken while
// it waits.
module rgb_to_terminal_palette_index
   import rtpi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ChanWidth-1:0]  req_red,
   input  logic [ChanWidth-1:0]  req_green,
   input  logic [ChanWidth-1:0]  req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IndexWidth-1:0] rsp_palette_index,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   logic      palette_select_ff;
   rgb_type   req_rgb;
   rgb_type   pixel;
   probe_type probe;
   dist_type  result;

   // palette select register
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_select_ff <= 1'b0;
      end else if (csr_write_enable) begin
         palette_select_ff <= csr_write_data;
      end
   end

   assign req_rgb = '{red: req_red, green: req_green, blue: req_blue};

   rtpi_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rgb           (req_rgb),
      .mode              (palette_select_ff),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_palette_index (rsp_palette_index),
      .pixel             (pixel),
      .probe             (probe),
      .result            (result)
   );

   rtpi_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .pixel  (pixel),
      .probe  (probe),
      .result (result)
   );

endmodule

[sv/rtpi_checker.sv]
// Port-level checker for the terminal palette index block, bound to the top.
// Depends on rtpi_pkg.
module rtpi_checker
   import rtpi_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [IndexWidth-1:0] rsp_palette_index
);

   logic [1:0] pending_ff, pending_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_acc && rsp_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_palette_index))
      else $error("response dropped or changed while stalled");

   // no response without an outstanding request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a request");

   // at most one request in the scan and one waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests outstanding");

   // the scan blocks new requests after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request taken during a scan");

endmodule

bind rgb_to_terminal_palette_index rtpi_checker u_rtpi_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_palette_index (rsp_palette_index)
);

[bench/rgb_to_terminal_palette_index_tb.sv]
// Self-checking bench for rgb_to_terminal_palette_index: random and directed colours
// in both palette modes, checked against a nearest-entry search held in the bench.
// Depends on rtpi_pkg and the rgb_to_terminal_palette_index RTL.
module rgb_to_terminal_palette_index_tb;
   import rtpi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ResetCycles = 8;
   localparam int PhaseCount  = 8;
   localparam int PhaseItems  = 135;
   localparam int HoldCycles  = 600;
   localparam int TailCycles  = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ChanWidth-1:0]  req_red = '0;
   logic [ChanWidth-1:0]  req_green = '0;
   logic [ChanWidth-1:0]  req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IndexWidth-1:0] rsp_palette_index;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data = 1'b0;

   // colours waiting to be driven, and palette indexes waiting to come back
   rgb_type               pending_colours[$];
   logic [IndexWidth-1:0] expected_indexes[$];

   int   queued_count = 0;
   int   checked_count = 0;
   int   error_count = 0;
   int   sender_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic req_accepted = 1'b0;
   logic wide_palette = 1'b0;
   bit   hold_toggle = 1'b0;
   bit   hold_seen = 1'b0;
   int   hold_left = 0;

   rgb_to_terminal_palette_index i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_palette_index (rsp_palette_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int chan_dist(logic [ChanWidth-1:0] a, logic [ChanWidth-1:0] b);
      int diff;
      diff = int'(a) - int'(b);
      return diff * diff;
   endfunction

   // full scan of the selected palette; <= lets the later entry win a tie
   function automatic logic [IndexWidth-1:0] nearest_entry(rgb_type c, logic wide);
      logic [ChanWidth-1:0] pr, pg, pb;
      int best_dist, best_pos, d, count;
      best_dist = 32'h7fffffff;
      best_pos = 0;
      count = wide ? CubeCount + GrayCount : AnsiCount;
      for (int i = 0; i < count; i++) begin
         if (!wide) begin
            {pr, pg, pb} = AnsiRgb[i];
         end else if (i < CubeCount) begin
            pr = CubeLevel[i / (CubeSide * CubeSide)];
            pg = CubeLevel[(i / CubeSide) % CubeSide];
            pb = CubeLevel[i % CubeSide];
         end else begin
            pr = ChanWidth'(GrayBase + GrayStep * (i - CubeCount));
            pg = pr;
            pb = pr;
         end
         d = chan_dist(c.red, pr) + chan_dist(c.green, pg) + chan_dist(c.blue, pb);
         if (d <= best_dist) begin
            best_dist = d;
            best_pos = i;
         end
      end
      return wide ? IndexWidth'(XtermBase + best_pos) : IndexWidth'(best_pos);
   endfunction

   // a channel near a palette level, or halfway between two cube levels
   function automatic logic [ChanWidth-1:0] near_level(logic wide);
      int v, k;
      k = $urandom_range(CubeSide - 2);
      if (wide && $urandom_range(2) == 0) begin
         v = (int'(CubeLevel[k]) + int'(CubeLevel[k + 1])) / 2;
      end else begin
         v = wide ? int'(CubeLevel[$urandom_range(CubeSide - 1)])
                  : int'(AnsiRgb[$urandom_range(AnsiCount - 1)][23:16]);
         v = v + int'($urandom_range(8)) - 4;
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return ChanWidth'(v);
   endfunction

   function automatic rgb_type random_colour(logic wide);
      rgb_type c;
      case ($urandom_range(3))
         0, 1: begin
            c.red = ChanWidth'($urandom);
            c.green = ChanWidth'($urandom);
            c.blue = ChanWidth'($urandom);
         end
         2: begin
            // grays and near-grays
            c.red = ChanWidth'($urandom);
            c.green = c.red ^ ChanWidth'($urandom_range(1));
            c.blue = c.red;
         end
         default: begin
            c.red = near_level(wide);
            c.green = near_level(wide);
            c.blue = near_level(wide);
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [IndexWidth-1:0] want,
                                  logic [IndexWidth-1:0] got);
      $display("%0t: %s: expected index %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // called at a rising edge only, so the driver never sees a half-updated queue
   task automatic queue_colour(logic [23:0] rgb);
      pending_colours.push_back(rgb_type'(rgb));
      queued_count++;
   endtask

   // sender pause: nothing new until every request has been answered
   task automatic wait_drained();
      do @(negedge clock); while (checked_count != queued_count);
      @(posedge clock);
   endtask

   task automatic set_palette(logic wide);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= wide;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // request driver: next colour once the current one is taken, with random gaps
   always @(negedge clock) begin : driver
      rgb_type colour;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_colours.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            colour = pending_colours.pop_front();
            req_red <= colour.red;
            req_green <= colour.green;
            req_blue <= colour.blue;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: random stalls, plus a long hold-off whenever hold_toggle flips
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HoldCycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: tracks the palette register, predicts on accept, checks on response
   always @(posedge clock) begin : monitor
      logic [IndexWidth-1:0] want;
      if (reset) begin
         wide_palette = 1'b0;
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (csr_write_enable) wide_palette = csr_write_data;
         if (req_valid && req_ready) begin
            expected_indexes.push_back(
               nearest_entry({req_red, req_green, req_blue}, wide_palette));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_indexes.size() == 0) begin
               report_mismatch("response with no request outstanding", '0, rsp_palette_index);
            end else begin
               want = expected_indexes.pop_front();
               if (rsp_palette_index !== want)
                  report_mismatch("palette_index", want, rsp_palette_index);
               checked_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int half;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ANSI palette at its reset setting: corners, primaries, and two ties
      queue_colour(24'h000000);
      queue_colour(24'hffffff);
      queue_colour(24'hc0c0c0);
      queue_colour(24'h808080);
      queue_colour(24'hff0000);
      queue_colour(24'h00ff00);
      queue_colour(24'h0000ff);
      queue_colour(24'h400000);   // black and dark red equally near
      queue_colour(24'ha0a0a0);   // silver and gray equally near
      queue_colour(24'h7f7f7f);
      queue_colour(24'h00ff80);
      wait_drained();

      // cube and gray palette: corners, gray ends, ties between two gray steps and two cube levels
      set_palette(1'b1);
      queue_colour(24'h000000);
      queue_colour(24'hffffff);
      queue_colour(24'h080808);
      queue_colour(24'heeeeee);
      queue_colour(24'h00005f);
      queue_colour(24'h0d0d0d);   // between two gray steps
      queue_colour(24'h730000);   // between two cube levels
      queue_colour(24'h73739b);
      queue_colour(24'hc3ebeb);
      queue_colour(24'h7f7f7f);
      queue_colour(24'hff00ff);
      queue_colour(24'h010203);
      wait_drained();

      // random phases: palette alternates, idle pattern changes every second phase
      for (int p = 0; p < PhaseCount; p++) begin
         set_palette(p[0]);
         case ((p / 2) % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin sender_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         half = PhaseItems / 2;
         for (int k = 0; k < half; k++) queue_colour(random_colour(p[0]));
         // first phase only: long response hold-off while requests are still queued
         if (p == 0) hold_toggle = ~hold_toggle;
         wait_drained();
         for (int k = half; k < PhaseItems; k++) queue_colour(random_colour(p[0]));
         wait_drained();
      end

      // let any stray response show up before the verdict
      repeat (TailCycles) @(negedge clock);
      while (expected_indexes.size() != 0)
         report_mismatch("no response for request", expected_indexes.pop_front(), '0);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
